// ----- hw/rtl/divider_64bit_signed_unsigned_assert.svh -----
// ---------------------------------------------------------------------------
// Divider assertion macros
// Shorthand for the concurrent checks at the end of the divider top level.
// ---------------------------------------------------------------------------
`ifndef DIVIDER_64BIT_SIGNED_UNSIGNED_ASSERT_SVH
`define DIVIDER_64BIT_SIGNED_UNSIGNED_ASSERT_SVH

// same-cycle implication, quiet during reset
`define DV_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, also checked through reset
`define DV_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/dv_pkg.sv -----
// ---------------------------------------------------------------------------
// Divider package
// Widths, action codes and the record handed along the divider pipeline.
// ---------------------------------------------------------------------------
package dv_pkg;

    localparam int unsigned DV_WIDTH  = 64;
    localparam int unsigned DV_STEPS  = DV_WIDTH;
    localparam int unsigned DV_ACT_W  = 2;

    typedef enum logic [DV_ACT_W-1:0] {
        ACT_UQUO = 2'd0,
        ACT_UREM = 2'd1,
        ACT_SQUO = 2'd2,
        ACT_NONE = 2'd3
    } dv_action_t;

    typedef struct packed {
        dv_action_t action;
        logic       flip;
    } dv_ctl_t;

    // pn: partial remainder in the upper half, dividend bits then quotient bits below
    typedef struct packed {
        logic [2*DV_WIDTH-1:0] pn;
        logic [DV_WIDTH-1:0]   den;
        dv_ctl_t               ctl;
    } dv_data_t;

endpackage

// ----- hw/rtl/divider_64bit_signed_unsigned.sv -----
// Pipeline: operand stage, 64 divider cells, result stage; one request per cycle unless
// the result side stalls. Each cell retires one quotient bit and passes it on.
// Every stage holds its own request, so bubbles close up while the result side stalls.
// Reset: aresetn synchronous, active low, empties all stages; data registers are not reset.
// ---------------------------------------------------------------------------
// 64-bit signed/unsigned divider
// Pipelined restoring divider: unsigned quotient, unsigned remainder, signed quotient.
// ---------------------------------------------------------------------------
module divider_64bit_signed_unsigned (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [2*dv_pkg::DV_WIDTH-1:0]   s_tdata,   // numerator[63:0], denominator[127:64]
    input  logic [dv_pkg::DV_ACT_W-1:0]     s_tuser,   // action[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dv_pkg::DV_WIDTH-1:0]     m_tdata    // result[63:0]
);
    import dv_pkg::*;

    `include "divider_64bit_signed_unsigned_assert.svh"

    logic     cell_valid [DV_STEPS+1];
    logic     cell_ready [DV_STEPS+1];
    dv_data_t cell_data  [DV_STEPS+1];
    logic     all_full;

    dv_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_num    (s_tdata[DV_WIDTH-1:0]),
        .in_den    (s_tdata[2*DV_WIDTH-1:DV_WIDTH]),
        .out_valid (cell_valid[0]),
        .out_ready (cell_ready[0]),
        .out_data  (cell_data[0])
    );

    for (genvar i = 0; i < DV_STEPS; i++) begin : g_cell
        dv_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[i]),
            .in_ready  (cell_ready[i]),
            .in_data   (cell_data[i]),
            .out_valid (cell_valid[i+1]),
            .out_ready (cell_ready[i+1]),
            .out_data  (cell_data[i+1])
        );
    end

    dv_post u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (cell_valid[DV_STEPS]),
        .in_ready   (cell_ready[DV_STEPS]),
        .in_data    (cell_data[DV_STEPS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_tdata)
    );

    always_comb begin
        all_full = m_tvalid;
        for (int k = 0; k <= DV_STEPS; k++) begin
            all_full = all_full && cell_valid[k];
        end
    end

    // input side only stalls once every stage is occupied
    `DV_ASSERT_IMPL(a_stall_only_full, aclk, aresetn, !s_tready, all_full, "stall with free stage")
    // finished remainder is below a non-zero divisor
    `DV_ASSERT_IMPL(a_rem_below_den, aclk, aresetn,
        cell_valid[DV_STEPS] && (cell_data[DV_STEPS].den != '0),
        cell_data[DV_STEPS].pn[2*DV_WIDTH-1:DV_WIDTH] < cell_data[DV_STEPS].den,
        "remainder not below divisor")
    `DV_ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid && !cell_valid[0],
        "pipeline not empty after reset")

endmodule

// ----- hw/rtl/dv_prep.sv -----
// ---------------------------------------------------------------------------
// Divider operand stage
// Takes operand magnitudes for signed requests and loads the first record.
// ---------------------------------------------------------------------------
module dv_prep (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dv_pkg::DV_ACT_W-1:0]   in_action,
    input  logic [dv_pkg::DV_WIDTH-1:0]   in_num,
    input  logic [dv_pkg::DV_WIDTH-1:0]   in_den,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dv_pkg::dv_data_t              out_data
);
    import dv_pkg::*;

    logic                valid_reg;
    dv_data_t            data_reg;
    dv_data_t            data_next;
    logic                is_signed;
    logic [DV_WIDTH-1:0] num_mag;
    logic [DV_WIDTH-1:0] den_mag;

    always_comb begin
        is_signed = (dv_action_t'(in_action) == ACT_SQUO);
        num_mag   = (is_signed && in_num[DV_WIDTH-1]) ? (~in_num + 1'b1) : in_num;
        den_mag   = (is_signed && in_den[DV_WIDTH-1]) ? (~in_den + 1'b1) : in_den;
        data_next.pn         = {{DV_WIDTH{1'b0}}, num_mag};
        data_next.den        = den_mag;
        data_next.ctl.action = dv_action_t'(in_action);
        data_next.ctl.flip   = is_signed && (in_num[DV_WIDTH-1] ^ in_den[DV_WIDTH-1]);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- hw/rtl/dv_cell.sv -----
// ---------------------------------------------------------------------------
// Divider cell
// One restoring shift-subtract step: retires one quotient bit per request.
// ---------------------------------------------------------------------------
module dv_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  dv_pkg::dv_data_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output dv_pkg::dv_data_t out_data
);
    import dv_pkg::*;

    logic                valid_reg;
    dv_data_t            data_reg;
    dv_data_t            data_next;
    logic                top;
    logic [DV_WIDTH-1:0] part;
    logic [DV_WIDTH:0]   diff;
    logic                ge;

    always_comb begin
        top  = in_data.pn[2*DV_WIDTH-1];
        part = in_data.pn[2*DV_WIDTH-2:DV_WIDTH-1];
        diff = {top, part} - {1'b0, in_data.den};
        ge   = !diff[DV_WIDTH];
        data_next.pn  = {(ge ? diff[DV_WIDTH-1:0] : part), in_data.pn[DV_WIDTH-2:0], ge};
        data_next.den = in_data.den;
        data_next.ctl = in_data.ctl;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- hw/rtl/dv_post.sv -----
// ---------------------------------------------------------------------------
// Divider result stage
// Picks quotient or remainder, applies the sign and holds the result.
// ---------------------------------------------------------------------------
module dv_post (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  dv_pkg::dv_data_t            in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dv_pkg::DV_WIDTH-1:0] out_result
);
    import dv_pkg::*;

    logic                valid_reg;
    logic [DV_WIDTH-1:0] result_reg;
    logic [DV_WIDTH-1:0] result_next;
    logic [DV_WIDTH-1:0] quo;
    logic [DV_WIDTH-1:0] rem;

    always_comb begin
        quo = in_data.pn[DV_WIDTH-1:0];
        rem = in_data.pn[2*DV_WIDTH-1:DV_WIDTH];
        case (in_data.ctl.action)
            ACT_UQUO: begin
                result_next = quo;
            end
            ACT_UREM: begin
                result_next = rem;
            end
            ACT_SQUO: begin
                result_next = in_data.ctl.flip ? (~quo + 1'b1) : quo;
            end
            default: begin
                result_next = '0;
            end
        endcase
    end

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- bench/divider_64bit_signed_unsigned_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Divider stream testbench
// Sends division requests, first a directed set of corner cases and then
// random operands of mixed sizes, into the 64-bit divider. Both stream sides
// stall at random. Each returned result is checked against a local model of
// the divider, in the order the requests went in.
// ---------------------------------------------------------------------------
module divider_64bit_signed_unsigned_test;

    import dv_pkg::*;

    localparam int          NUM_RANDOM = 900;
    localparam int          IDLE_LIMIT = 2000;
    localparam logic [63:0] MIN_S64    = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_S64    = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] ALL_ONES   = 64'hffff_ffff_ffff_ffff;

    typedef struct {
        dv_action_t  action;
        logic [63:0] numerator;
        logic [63:0] denominator;
        logic        drain;     // hold off until every result is back
    } div_request_t;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [127:0]  s_tdata  = '0;   // numerator[63:0], denominator[127:64]
    logic [1:0]    s_tuser  = '0;   // action[1:0]
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [63:0]   m_tdata;         // result[63:0]

    div_request_t  pending_requests[$];
    logic [63:0]   expected_results[$];
    int            fail_count  = 0;
    int            send_gap    = 0;
    int            send_calm   = 0;
    int            recv_stall  = 0;
    int            recv_calm   = 0;
    int            idle_cycles = 0;

    divider_64bit_signed_unsigned uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic [63:0] divide_result(dv_action_t action, logic [63:0] num,
                                                  logic [63:0] den);
        logic [63:0] num_mag;
        logic [63:0] den_mag;
        logic [63:0] quo;
        logic        flip;
        case (action)
            ACT_UQUO: return (den == '0) ? ALL_ONES : num / den;
            ACT_UREM: return (den == '0) ? num : num % den;
            ACT_SQUO: begin
                num_mag = num[63] ? -num : num;
                den_mag = den[63] ? -den : den;
                flip    = num[63] ^ den[63];
                quo     = (den_mag == '0) ? ALL_ONES : num_mag / den_mag;
                return flip ? -quo : quo;
            end
            default: return '0;
        endcase
    endfunction

    // wait length per request; now and then a run with no waiting at all
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            3, 4: v = v >> $urandom_range(1, 63);
            5:    v = 64'($urandom_range(0, 3));
            6:    v = -(v >> $urandom_range(1, 63));
            7: begin
                case ($urandom_range(0, 4))
                    0: v = '0;
                    1: v = 64'd1;
                    2: v = ALL_ONES;
                    3: v = MIN_S64;
                    default: v = MAX_S64;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_request(dv_action_t action, logic [63:0] num, logic [63:0] den,
                                 logic drain = 1'b0);
        div_request_t req;
        req.action      = action;
        req.numerator   = num;
        req.denominator = den;
        req.drain       = drain;
        pending_requests.push_back(req);
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin : drive_requests
        logic vld_n;
        int   gap_n;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            vld_n = s_tvalid;
            gap_n = send_gap;
            if (s_tvalid && s_tready) begin
                expected_results.push_back(divide_result(dv_action_t'(s_tuser),
                                                         s_tdata[63:0], s_tdata[127:64]));
                vld_n = 1'b0;
                gap_n = draw_wait(send_calm);
            end
            if (!vld_n) begin
                if (gap_n > 0) begin
                    gap_n--;
                end else if (pending_requests.size() != 0 &&
                             (!pending_requests[0].drain || expected_results.size() == 0)) begin
                    s_tdata <= {pending_requests[0].denominator, pending_requests[0].numerator};
                    s_tuser <= pending_requests[0].action;
                    vld_n = 1'b1;
                    void'(pending_requests.pop_front());
                end
            end
            s_tvalid <= vld_n;
            send_gap <= gap_n;
        end
    end

    always @(posedge aclk) begin : check_results
        logic [63:0] want;
        int          stall_n;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end else begin
            stall_n = recv_stall;
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request outstanding", m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("result %h, want %h", m_tdata, want));
                end
                stall_n = draw_wait(recv_calm);
            end
            if (stall_n > 0) begin
                stall_n--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            recv_stall <= stall_n;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        dv_action_t act;

        queue_request(ACT_UQUO, 64'd100, 64'd7);
        queue_request(ACT_UREM, 64'd100, 64'd7);
        queue_request(ACT_SQUO, -64'sd100, 64'd7);
        queue_request(ACT_SQUO, 64'd100, -64'sd7);
        queue_request(ACT_SQUO, -64'sd100, -64'sd7);
        queue_request(ACT_UQUO, ALL_ONES, 64'd1);
        queue_request(ACT_UQUO, ALL_ONES, ALL_ONES);
        queue_request(ACT_UREM, 64'd5, ALL_ONES);
        queue_request(ACT_UQUO, '0, ALL_ONES);
        queue_request(ACT_UQUO, ALL_ONES, MIN_S64);
        queue_request(ACT_UREM, ALL_ONES, MIN_S64);
        // zero denominator
        queue_request(ACT_UQUO, 64'h0123_4567_89ab_cdef, '0);
        queue_request(ACT_UREM, 64'hfedc_ba98_7654_3210, '0);
        queue_request(ACT_SQUO, 64'h0123_4567_89ab_cdef, '0);
        queue_request(ACT_SQUO, 64'hfedc_ba98_7654_3210, '0);
        queue_request(ACT_SQUO, '0, '0);
        // signed extremes; minimum over minus one wraps
        queue_request(ACT_SQUO, MIN_S64, ALL_ONES);
        queue_request(ACT_SQUO, MIN_S64, 64'd1);
        queue_request(ACT_SQUO, MAX_S64, ALL_ONES);
        queue_request(ACT_SQUO, MIN_S64, MIN_S64);
        queue_request(ACT_SQUO, ALL_ONES, ALL_ONES);
        // unused action code
        queue_request(ACT_NONE, 64'hdead_beef_cafe_f00d, 64'd3);
        queue_request(ACT_NONE, '0, '0);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            act = ($urandom_range(0, 15) == 0) ? ACT_NONE : dv_action_t'($urandom_range(0, 2));
            queue_request(act, pick_operand(), pick_operand(), (i % 300) == 0);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
